// ===== src/encoder_bounded_value_adjust_macros.svh =====
// assertion helpers for the value adjust block
`ifndef ENCODER_BOUNDED_VALUE_ADJUST_MACROS_SVH
`define ENCODER_BOUNDED_VALUE_ADJUST_MACROS_SVH

// same-cycle implication, clocked on aclk, off during reset
`define EBVA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on aclk, off during reset
`define EBVA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/ebva_pkg.sv =====
`default_nettype none
package ebva_pkg;

    localparam int unsigned VALUE_W = 16;
    localparam int unsigned SCALE_W = 8;
    localparam int unsigned ADDR_W  = 5;
    localparam int unsigned DATA_W  = 32;

    localparam logic [VALUE_W-1:0] WRAP_JUMP          = 16'h3F00;
    localparam logic [VALUE_W-1:0] FULL_TOP           = 16'hFFFF;
    localparam logic [VALUE_W-1:0] QUARTER_TOP        = 16'h3FFF;
    localparam logic [VALUE_W-1:0] RELOAD_TOP_FULL    = 16'd65535;
    localparam logic [VALUE_W-1:0] RELOAD_TOP_QUARTER = 16'(65532 >> 2);
    localparam logic [SCALE_W-1:0] SCALE_LIMIT        = 8'd200;

    localparam logic [1:0] RELOAD_NONE = 2'd0;
    localparam logic [1:0] RELOAD_TOP  = 2'd1;
    localparam logic [1:0] RELOAD_ZERO = 2'd2;

    localparam logic [2:0] REG_MIN_VALUE      = 3'd0;
    localparam logic [2:0] REG_MAX_VALUE      = 3'd1;
    localparam logic [2:0] REG_WRAP_MODE      = 3'd2;
    localparam logic [2:0] REG_STEP_SCALE     = 3'd3;
    localparam logic [2:0] REG_DIVIDE_BY_FOUR = 3'd4;

    typedef struct packed {
        logic [VALUE_W-1:0] raw_count;
        logic [VALUE_W-1:0] current_value;
    } in_item_t;

    typedef struct packed {
        logic [VALUE_W-1:0] new_value;
        logic [1:0]         counter_reload;
    } out_item_t;

    typedef struct packed {
        logic [VALUE_W-1:0] min_value;
        logic [VALUE_W-1:0] max_value;
        logic               wrap_mode;
        logic [SCALE_W-1:0] step_scale;
        logic               divide_by_four;
    } cfg_t;

endpackage
`default_nettype wire

// ===== src/ebva_regs.sv =====
`default_nettype none
module ebva_regs (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [ebva_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [ebva_pkg::DATA_W-1:0]   pwdata,
    output logic      [ebva_pkg::DATA_W-1:0]   prdata,
    output ebva_pkg::cfg_t                     cfg
);

    ebva_pkg::cfg_t cfg_reg;
    logic [2:0]     reg_idx;
    logic           wr_en;

    assign reg_idx = paddr[ebva_pkg::ADDR_W-1:2];
    assign wr_en   = psel & penable & pwrite;
    assign cfg     = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.min_value      <= '0;
            cfg_reg.max_value      <= '1;
            cfg_reg.wrap_mode      <= 1'b0;
            cfg_reg.step_scale     <= '0;
            cfg_reg.divide_by_four <= 1'b0;
        end else if (wr_en) begin
            case (reg_idx)
                ebva_pkg::REG_MIN_VALUE:
                    cfg_reg.min_value <= pwdata[ebva_pkg::VALUE_W-1:0];
                ebva_pkg::REG_MAX_VALUE:
                    cfg_reg.max_value <= pwdata[ebva_pkg::VALUE_W-1:0];
                ebva_pkg::REG_WRAP_MODE:
                    cfg_reg.wrap_mode <= pwdata[0];
                ebva_pkg::REG_STEP_SCALE:
                    cfg_reg.step_scale <= pwdata[ebva_pkg::SCALE_W-1:0];
                ebva_pkg::REG_DIVIDE_BY_FOUR:
                    cfg_reg.divide_by_four <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            ebva_pkg::REG_MIN_VALUE:
                prdata = {16'd0, cfg_reg.min_value};
            ebva_pkg::REG_MAX_VALUE:
                prdata = {16'd0, cfg_reg.max_value};
            ebva_pkg::REG_WRAP_MODE:
                prdata = {31'd0, cfg_reg.wrap_mode};
            ebva_pkg::REG_STEP_SCALE:
                prdata = {24'd0, cfg_reg.step_scale};
            ebva_pkg::REG_DIVIDE_BY_FOUR:
                prdata = {31'd0, cfg_reg.divide_by_four};
            default:
                prdata = '0;
        endcase
    end

endmodule
`default_nettype wire

// ===== src/ebva_step.sv =====
`default_nettype none
module ebva_step (
    input  wire ebva_pkg::in_item_t            item,
    input  wire ebva_pkg::cfg_t                cfg,
    input  wire logic [ebva_pkg::VALUE_W-1:0]  last_count,
    output ebva_pkg::out_item_t                result,
    output logic      [ebva_pkg::VALUE_W-1:0]  last_count_next
);

    always_comb begin
        logic [15:0] reading;
        logic [15:0] top;
        logic [15:0] span;
        logic [15:0] comp;
        logic [15:0] mag;
        logic [15:0] diff;
        logic [15:0] sum;
        logic [23:0] prod;
        logic        minus;
        logic        under;

        reading = cfg.divide_by_four ? {2'b00, item.raw_count[15:2]} : item.raw_count;
        top     = cfg.divide_by_four ? ebva_pkg::QUARTER_TOP : ebva_pkg::FULL_TOP;

        // signed step with counter wraparound
        if (last_count > reading) begin
            span  = last_count - reading;
            comp  = top - span;
            minus = span < ebva_pkg::WRAP_JUMP;
            mag   = minus ? span : comp;
        end else begin
            span  = reading - last_count;
            comp  = top - span;
            minus = span > ebva_pkg::WRAP_JUMP;
            if (minus) begin
                mag = (comp == 16'd0) ? 16'd1 : comp;
            end else begin
                mag = span;
            end
        end

        prod = {8'd0, mag} * {16'd0, cfg.step_scale};
        if (cfg.step_scale != 8'd0 && cfg.step_scale < ebva_pkg::SCALE_LIMIT) begin
            mag = prod[15:0];
        end

        diff  = item.current_value - mag;
        sum   = item.current_value + mag;
        under = (item.current_value < mag) || (diff < cfg.min_value);

        result.new_value      = item.current_value;
        result.counter_reload = ebva_pkg::RELOAD_NONE;
        last_count_next       = last_count;

        if (reading != last_count) begin
            last_count_next = reading;
            if (minus) begin
                if (!under) begin
                    result.new_value = diff;
                end else if (cfg.wrap_mode) begin
                    result.new_value = cfg.max_value;
                end else begin
                    result.new_value      = cfg.min_value;
                    result.counter_reload = ebva_pkg::RELOAD_TOP;
                    last_count_next       = cfg.divide_by_four ?
                                            ebva_pkg::RELOAD_TOP_QUARTER :
                                            ebva_pkg::RELOAD_TOP_FULL;
                end
            end else begin
                if (sum <= cfg.max_value) begin
                    result.new_value = sum;
                end else if (cfg.wrap_mode) begin
                    result.new_value = cfg.min_value;
                end else begin
                    result.new_value      = cfg.max_value;
                    result.counter_reload = ebva_pkg::RELOAD_ZERO;
                    last_count_next       = '0;
                end
            end
        end
    end

endmodule
`default_nettype wire

// ===== src/encoder_bounded_value_adjust.sv =====
// Rotary encoder value adjuster.
// Input channel (s_valid/s_ready/s_data) carries a raw quadrature counter
// reading and the value being edited; result channel (m_valid/m_ready/m_data)
// returns the adjusted value and a counter reload code (none, top, zero).
// Limits, wrap or clamp mode, step scale and divide-by-four are set over the
// APB port; the user must set them only while no request is in flight, which
// the block does not enforce; pready is always high.
// A request accepted passes through the input register, then the result
// register that drives m_data, moving on once the result side is free.
// Throughput: one request per cycle while m_ready is high; the step logic and
// the last-count register form a loop between the two registers.
// Reset clears both valid flags, the last count and the configuration registers.
// When the receiver stalls, the result register holds and the input
// register still takes one more request; s_ready drops only when both are
// full and m_ready is low.
`default_nettype none
module encoder_bounded_value_adjust (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire ebva_pkg::in_item_t            s_data,
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output ebva_pkg::out_item_t                m_data,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [ebva_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [ebva_pkg::DATA_W-1:0]   pwdata,
    output logic      [ebva_pkg::DATA_W-1:0]   prdata,
    output logic                               pready
);

    ebva_pkg::cfg_t      cfg;
    ebva_pkg::in_item_t  in_data_reg;
    logic                in_valid_reg;
    ebva_pkg::out_item_t out_data_reg;
    ebva_pkg::out_item_t out_data_next;
    logic                out_valid_reg;
    logic [15:0]         last_count_reg;
    logic [15:0]         last_count_next;
    logic                advance;

    assign pready  = 1'b1;
    assign advance = in_valid_reg & (~out_valid_reg | m_ready);
    assign s_ready = ~in_valid_reg | advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    ebva_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .cfg     (cfg)
    );

    ebva_step u_step (
        .item            (in_data_reg),
        .cfg             (cfg),
        .last_count      (last_count_reg),
        .result          (out_data_next),
        .last_count_next (last_count_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            last_count_reg <= '0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg  <= 1'b1;
                last_count_reg <= last_count_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
        if (advance) begin
            out_data_reg <= out_data_next;
        end
    end

endmodule
`default_nettype wire

// ===== src/ebva_checker.sv =====
`default_nettype none
`include "encoder_bounded_value_adjust_macros.svh"
module ebva_checker (
    input wire logic                aclk,
    input wire logic                aresetn,
    input wire logic                s_ready,
    input wire logic                m_valid,
    input wire logic                m_ready,
    input wire ebva_pkg::out_item_t m_data
);

    `EBVA_ASSERT_NXT(a_result_hold, m_valid && !m_ready, m_valid && $stable(m_data), "result changed while stalled")
    `EBVA_ASSERT_IMP(a_reload_code, m_valid, m_data.counter_reload <= ebva_pkg::RELOAD_ZERO, "illegal reload code")
    `EBVA_ASSERT_IMP(a_backpressure, !s_ready, m_valid && !m_ready, "input stalled without output stall")

endmodule

bind encoder_bounded_value_adjust ebva_checker u_ebva_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
`default_nettype wire
